FILE: design/arpnc_pkg.sv
// arpnc_pkg: shared types and constants for the arp neighbor cache
// no dependencies
`default_nettype none
package arpnc_pkg;
    localparam int BUCKETS_DEF = 256;
    localparam int WAYS_DEF    = 4;

    localparam logic [15:0] MIN_FRAME   = 16'd42;
    localparam logic [15:0] HW_ETHERNET = 16'd1;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [7:0]  HW_LEN_ETH  = 8'd6;
    localparam logic [7:0]  PROTO_LEN4  = 8'd4;

    typedef enum logic [1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_ADD    = 2'd1,
        FUNC_LEARN  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_MALFORM  = 3'd2,
        ST_CONFLICT = 3'd3,
        ST_IGNORED  = 3'd4
    } status_t;

    localparam logic CFG_LOCAL_IP       = 1'b0;
    localparam logic CFG_LOCAL_IP_VALID = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DONE,
        S_CLEAR
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic resolve;
        logic out_take;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic out_full;
    } sts_t;
endpackage
`default_nettype wire

FILE: design/arp_neighbor_cache_top.sv
// arp_neighbor_cache_top: ipv4 arp neighbor cache, set-associative table
// depends on arpnc_pkg, arpnc_ctrl, arpnc_dp
//
// input beats on s_* (valid/ready) carry a lookup, add or learn request.
// each beat gives exactly one result beat on m_* (valid/ready).
// cfg_valid/cfg_ready with cfg_index and cfg_data write local_ip (index 0)
// and local_ip_valid (index 1); cfg_ready is always high.
// the controller takes one item at a time: it registers the request, then
// does one registered read of the bucket row, then resolves the result,
// with one write-back of a way for a store; s_ready stays low until then.
// the output register frees the datapath; a stalled m_ready holds the
// next result in the resolve step and blocks further input until taken.
// reset: a clearing pass walks every bucket and zeroes its valid row, with
// s_ready low meanwhile; config writes are taken during the pass.
`default_nettype none
module arp_neighbor_cache_top #(
    parameter int BUCKETS = arpnc_pkg::BUCKETS_DEF,
    parameter int WAYS    = arpnc_pkg::WAYS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire         cfg_index,
    input  wire  [31:0] cfg_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_func,
    input  wire  [31:0] s_ip_addr,
    input  wire  [31:0] s_target_ip,
    input  wire  [47:0] s_mac_addr,
    input  wire  [7:0]  s_port_id,
    input  wire         s_may_request,
    input  wire  [15:0] s_frame_length,
    input  wire  [15:0] s_hw_type,
    input  wire  [15:0] s_proto_type,
    input  wire  [7:0]  s_hw_len,
    input  wire  [7:0]  s_proto_len,
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_hit,
    output logic [47:0] m_found_mac,
    output logic [7:0]  m_found_port,
    output logic        m_request_needed,
    output logic [2:0]  m_status
);
    arpnc_pkg::cmd_t cmd;
    arpnc_pkg::sts_t sts;
    logic [31:0] local_ip_reg;
    logic        local_ip_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_ip_reg       <= '0;
            local_ip_valid_reg <= 1'b0;
        end else if (cfg_valid) begin
            if (cfg_index == arpnc_pkg::CFG_LOCAL_IP) begin
                local_ip_reg <= cfg_data;
            end else begin
                local_ip_valid_reg <= cfg_data[0];
            end
        end
    end

    arpnc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    arpnc_dp #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .local_ip         (local_ip_reg),
        .local_ip_valid   (local_ip_valid_reg),
        .s_func           (s_func),
        .s_ip_addr        (s_ip_addr),
        .s_target_ip      (s_target_ip),
        .s_mac_addr       (s_mac_addr),
        .s_port_id        (s_port_id),
        .s_may_request    (s_may_request),
        .s_frame_length   (s_frame_length),
        .s_hw_type        (s_hw_type),
        .s_proto_type     (s_proto_type),
        .s_hw_len         (s_hw_len),
        .s_proto_len      (s_proto_len),
        .m_valid          (m_valid),
        .m_hit            (m_hit),
        .m_found_mac      (m_found_mac),
        .m_found_port     (m_found_port),
        .m_request_needed (m_request_needed),
        .m_status         (m_status)
    );
endmodule
`default_nettype wire

FILE: design/arpnc_ctrl.sv
// arpnc_ctrl: controller fsm sequencing clear, read and resolve
// depends on arpnc_pkg
`default_nettype none
module arpnc_ctrl (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire               m_ready,
    input  arpnc_pkg::sts_t   sts,
    output arpnc_pkg::cmd_t   cmd
);
    arpnc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= arpnc_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        cmd.out_take = m_ready;
        unique case (state_reg)
            arpnc_pkg::S_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clear_done) begin
                    state_next = arpnc_pkg::S_IDLE;
                end
            end
            arpnc_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = arpnc_pkg::S_READ;
                end
            end
            arpnc_pkg::S_READ: begin
                state_next = arpnc_pkg::S_DONE;
            end
            arpnc_pkg::S_DONE: begin
                if (!sts.out_full || m_ready) begin
                    cmd.resolve = 1'b1;
                    state_next  = arpnc_pkg::S_IDLE;
                end
            end
            default: state_next = arpnc_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: design/arpnc_dp.sv
// arpnc_dp: bucket memories, way compare, counters and output register
// depends on arpnc_pkg
`default_nettype none
module arpnc_dp #(
    parameter int BUCKETS = arpnc_pkg::BUCKETS_DEF,
    parameter int WAYS    = arpnc_pkg::WAYS_DEF
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  arpnc_pkg::cmd_t   cmd,
    output arpnc_pkg::sts_t   sts,
    input  wire        [31:0] local_ip,
    input  wire               local_ip_valid,
    input  wire        [1:0]  s_func,
    input  wire        [31:0] s_ip_addr,
    input  wire        [31:0] s_target_ip,
    input  wire        [47:0] s_mac_addr,
    input  wire        [7:0]  s_port_id,
    input  wire               s_may_request,
    input  wire        [15:0] s_frame_length,
    input  wire        [15:0] s_hw_type,
    input  wire        [15:0] s_proto_type,
    input  wire        [7:0]  s_hw_len,
    input  wire        [7:0]  s_proto_len,
    output logic              m_valid,
    output logic              m_hit,
    output logic       [47:0] m_found_mac,
    output logic       [7:0]  m_found_port,
    output logic              m_request_needed,
    output logic       [2:0]  m_status
);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int EW = 88;

    // one row per bucket: valid bits in one memory, entries per way
    logic [WAYS-1:0] vmem [BUCKETS];
    logic [EW-1:0]   emem [BUCKETS][WAYS];

    logic [BW-1:0]   clr_reg;
    logic [BW-1:0]   bkt_reg;
    logic [1:0]      func_reg;
    logic [31:0]     ip_reg, tip_reg;
    logic [47:0]     mac_reg;
    logic [7:0]      port_reg;
    logic            req_reg, hdr_ok_reg;
    logic [WAYS-1:0] vrow_reg;
    logic [EW-1:0]   erow_reg [WAYS];
    logic [31:0]     conflict_count_reg, miss_count_reg;

    logic [15:0] hash;
    assign hash = s_ip_addr[15:0] ^ s_ip_addr[31:16];

    assign sts.clear_done = (clr_reg == BW'(BUCKETS - 1));
    assign sts.out_full   = m_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clear) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bkt_reg    <= hash[BW-1:0];
            func_reg   <= s_func;
            ip_reg     <= s_ip_addr;
            tip_reg    <= s_target_ip;
            mac_reg    <= s_mac_addr;
            port_reg   <= s_port_id;
            req_reg    <= s_may_request;
            hdr_ok_reg <= (s_frame_length >= arpnc_pkg::MIN_FRAME)
                && (s_hw_type == arpnc_pkg::HW_ETHERNET)
                && (s_hw_len == arpnc_pkg::HW_LEN_ETH)
                && (s_proto_len == arpnc_pkg::PROTO_LEN4)
                && (s_proto_type == arpnc_pkg::PROTO_IPV4);
        end
    end

    // registered bucket read
    always_ff @(posedge aclk) begin
        vrow_reg <= vmem[bkt_reg];
        for (int w = 0; w < WAYS; w++) begin
            erow_reg[w] <= emem[bkt_reg][w];
        end
    end

    logic [WAYS-1:0] match;
    logic            any_match, any_free;
    logic [WW-1:0]   match_way, free_way;
    logic [EW-1:0]   match_ent;

    always_comb begin
        match     = '0;
        any_match = 1'b0;
        any_free  = 1'b0;
        match_way = '0;
        free_way  = '0;
        match_ent = '0;
        for (int w = 0; w < WAYS; w++) begin
            match[w] = vrow_reg[w] && (erow_reg[w][87:56] == ip_reg);
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                any_match = 1'b1;
                match_way = WW'(w);
                match_ent = erow_reg[w];
            end
            if (!vrow_reg[w]) begin
                any_free = 1'b1;
                free_way = WW'(w);
            end
        end
    end

    logic          is_local, do_store, store_ok, wr_en, miss_inc, conf_inc;
    logic [WW-1:0] wr_way;
    logic          r_hit, r_req;
    logic [47:0]   r_mac;
    logic [7:0]    r_port;
    logic [2:0]    r_status;

    always_comb begin
        is_local = local_ip_valid && (ip_reg == local_ip);
        do_store = 1'b0;
        miss_inc = 1'b0;
        conf_inc = 1'b0;
        r_hit    = 1'b0;
        r_req    = 1'b0;
        r_mac    = '0;
        r_port   = '0;
        r_status = arpnc_pkg::ST_OK;
        unique case (arpnc_pkg::func_t'(func_reg))
            arpnc_pkg::FUNC_LOOKUP: begin
                if (any_match) begin
                    r_hit  = 1'b1;
                    r_mac  = match_ent[55:8];
                    r_port = match_ent[7:0];
                end else if (req_reg) begin
                    r_req = 1'b1;
                end else begin
                    miss_inc = 1'b1;
                end
            end
            arpnc_pkg::FUNC_ADD: do_store = 1'b1;
            arpnc_pkg::FUNC_LEARN: begin
                priority if (!hdr_ok_reg) begin
                    r_status = arpnc_pkg::ST_MALFORM;
                end else if (is_local) begin
                    if (ip_reg != tip_reg) begin
                        conf_inc = 1'b1;
                        r_status = arpnc_pkg::ST_CONFLICT;
                    end else begin
                        r_status = arpnc_pkg::ST_IGNORED;
                    end
                end else if (ip_reg == 32'd0) begin
                    r_status = arpnc_pkg::ST_IGNORED;
                end else begin
                    do_store = 1'b1;
                end
            end
            default: r_status = arpnc_pkg::ST_IGNORED;
        endcase
        store_ok = any_match || any_free;
        wr_way   = any_match ? match_way : free_way;
        wr_en    = do_store && store_ok && cmd.resolve;
        if (do_store) begin
            r_hit    = any_match;
            r_status = store_ok ? arpnc_pkg::ST_OK : arpnc_pkg::ST_FULL;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            vmem[clr_reg] <= '0;
        end else if (wr_en) begin
            vmem[bkt_reg] <= vrow_reg | (WAYS'(1) << wr_way);
        end
        if (wr_en) begin
            emem[bkt_reg][wr_way] <= {ip_reg, mac_reg, port_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conflict_count_reg <= '0;
            miss_count_reg     <= '0;
        end else if (cmd.resolve) begin
            if (conf_inc) conflict_count_reg <= conflict_count_reg + 32'd1;
            if (miss_inc) miss_count_reg <= miss_count_reg + 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.resolve) begin
            m_valid <= 1'b1;
        end else if (cmd.out_take) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.resolve) begin
            m_hit            <= r_hit;
            m_found_mac      <= r_mac;
            m_found_port     <= r_port;
            m_request_needed <= r_req;
            m_status         <= r_status;
        end
    end
endmodule
`default_nettype wire

FILE: tb/tb.sv
// tb: self-checking testbench for arp_neighbor_cache_top
// depends on arpnc_pkg and the arp neighbor cache rtl; holds its own cache predictor
`timescale 1ns / 100ps
`default_nettype none
module tb;
    localparam int NB = arpnc_pkg::BUCKETS_DEF;
    localparam int NW = arpnc_pkg::WAYS_DEF;
    localparam int LIMIT = 2000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    wire         s_ready;
    logic [1:0]  s_func = '0;
    logic [31:0] s_ip_addr = '0;
    logic [31:0] s_target_ip = '0;
    logic [47:0] s_mac_addr = '0;
    logic [7:0]  s_port_id = '0;
    logic        s_may_request = 1'b0;
    logic [15:0] s_frame_length = '0;
    logic [15:0] s_hw_type = '0;
    logic [15:0] s_proto_type = '0;
    logic [7:0]  s_hw_len = '0;
    logic [7:0]  s_proto_len = '0;
    wire         m_valid;
    logic        m_ready = 1'b0;
    wire         m_hit;
    wire  [47:0] m_found_mac;
    wire  [7:0]  m_found_port;
    wire         m_request_needed;
    wire  [2:0]  m_status;

    arp_neighbor_cache_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func), .s_ip_addr(s_ip_addr),
        .s_target_ip(s_target_ip), .s_mac_addr(s_mac_addr), .s_port_id(s_port_id),
        .s_may_request(s_may_request), .s_frame_length(s_frame_length),
        .s_hw_type(s_hw_type), .s_proto_type(s_proto_type), .s_hw_len(s_hw_len),
        .s_proto_len(s_proto_len),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit), .m_found_mac(m_found_mac),
        .m_found_port(m_found_port), .m_request_needed(m_request_needed),
        .m_status(m_status)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    typedef struct {
        logic                 hit;
        logic [47:0]          mac;
        logic [7:0]           port;
        logic                 req;
        arpnc_pkg::status_t   status;
    } answer_t;

    // predicted cache contents
    logic        tbl_valid [NB*NW];
    logic [31:0] tbl_ip    [NB*NW];
    logic [47:0] tbl_mac   [NB*NW];
    logic [7:0]  tbl_port  [NB*NW];
    logic [31:0] conflicts;
    logic [31:0] misses;
    logic [31:0] my_ip;
    logic        my_ip_on;

    answer_t     answers_due [$];
    int          errors;
    int          n_sent;
    int          n_checked;
    int          n_hits;
    int          n_full;
    int          n_conflict;
    longint      cycles;
    bit          hold_off;
    bit          no_sink_gaps;
    bit          no_src_gaps;
    logic [31:0] recent_ips [$];

    function automatic int bucket_of(logic [31:0] ip);
        logic [15:0] h;
        h = ip[15:0] ^ ip[31:16];
        return int'(h & 16'(NB - 1)) * NW;
    endfunction

    function automatic int find_way(logic [31:0] ip);
        int b;
        b = bucket_of(ip);
        for (int w = 0; w < NW; w++)
            if (tbl_valid[b+w] && tbl_ip[b+w] == ip) return b + w;
        return -1;
    endfunction

    function automatic arpnc_pkg::status_t cache_store(logic [31:0] ip, logic [47:0] mac,
                                                       logic [7:0] port, output logic hit);
        int i;
        int b;
        hit = 1'b0;
        i = find_way(ip);
        if (i >= 0) begin
            tbl_mac[i] = mac;
            tbl_port[i] = port;
            hit = 1'b1;
            return arpnc_pkg::ST_OK;
        end
        b = bucket_of(ip);
        for (int w = 0; w < NW; w++) begin
            if (!tbl_valid[b+w]) begin
                tbl_valid[b+w] = 1'b1;
                tbl_ip[b+w] = ip;
                tbl_mac[b+w] = mac;
                tbl_port[b+w] = port;
                return arpnc_pkg::ST_OK;
            end
        end
        return arpnc_pkg::ST_FULL;
    endfunction

    function automatic answer_t predict_answer(arpnc_pkg::func_t f, logic [31:0] ip,
            logic [31:0] tip, logic [47:0] mac, logic [7:0] port, logic mreq,
            logic [15:0] flen, logic [15:0] hwt, logic [15:0] prt, logic [7:0] hwl,
            logic [7:0] prl);
        answer_t a;
        int i;
        a = '{hit: 1'b0, mac: '0, port: '0, req: 1'b0, status: arpnc_pkg::ST_OK};
        case (f)
            arpnc_pkg::FUNC_LOOKUP: begin
                i = find_way(ip);
                if (i >= 0) begin
                    a.hit = 1'b1;
                    a.mac = tbl_mac[i];
                    a.port = tbl_port[i];
                end else if (mreq) begin
                    a.req = 1'b1;
                end else begin
                    misses = misses + 1;
                end
            end
            arpnc_pkg::FUNC_ADD: a.status = cache_store(ip, mac, port, a.hit);
            arpnc_pkg::FUNC_LEARN: begin
                if (flen < arpnc_pkg::MIN_FRAME || hwt != arpnc_pkg::HW_ETHERNET ||
                    hwl != arpnc_pkg::HW_LEN_ETH || prl != arpnc_pkg::PROTO_LEN4 ||
                    prt != arpnc_pkg::PROTO_IPV4) begin
                    a.status = arpnc_pkg::ST_MALFORM;
                end else if (my_ip_on && ip == my_ip) begin
                    if (ip != tip) begin
                        conflicts = conflicts + 1;
                        a.status = arpnc_pkg::ST_CONFLICT;
                    end else begin
                        a.status = arpnc_pkg::ST_IGNORED;
                    end
                end else if (ip == 32'd0) begin
                    a.status = arpnc_pkg::ST_IGNORED;
                end else begin
                    a.status = cache_store(ip, mac, port, a.hit);
                end
            end
            default: a.status = arpnc_pkg::ST_IGNORED;
        endcase
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on result %0d: %s got %0h want %0h", n_checked, what, got, want);
        errors++;
    endtask

    task automatic wait_cycles(int n);
        repeat (n) @(posedge aclk);
    endtask

    // one item beat, with a random lead-in gap; valid stays up until the next gap or idle
    task automatic send_item(arpnc_pkg::func_t f, logic [31:0] ip, logic [31:0] tip,
            logic [47:0] mac, logic [7:0] port, logic mreq, logic [15:0] flen,
            logic [15:0] hwt, logic [15:0] prt, logic [7:0] hwl, logic [7:0] prl);
        int gap;
        gap = no_src_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            wait_cycles(gap);
        end
        s_valid <= 1'b1;
        s_func <= f;
        s_ip_addr <= ip;
        s_target_ip <= tip;
        s_mac_addr <= mac;
        s_port_id <= port;
        s_may_request <= mreq;
        s_frame_length <= flen;
        s_hw_type <= hwt;
        s_proto_type <= prt;
        s_hw_len <= hwl;
        s_proto_len <= prl;
        do @(posedge aclk); while (!s_ready);
        answers_due.push_back(predict_answer(f, ip, tip, mac, port, mreq, flen, hwt, prt,
                                             hwl, prl));
        n_sent++;
    endtask

    task automatic send_learn(logic [31:0] ip, logic [31:0] tip, logic [47:0] mac,
                              logic [7:0] port);
        send_item(arpnc_pkg::FUNC_LEARN, ip, tip, mac, port, 1'b0, arpnc_pkg::MIN_FRAME,
                  arpnc_pkg::HW_ETHERNET, arpnc_pkg::PROTO_IPV4, arpnc_pkg::HW_LEN_ETH,
                  arpnc_pkg::PROTO_LEN4);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge aclk);
        wait_cycles(6);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == arpnc_pkg::CFG_LOCAL_IP) my_ip = val;
        else my_ip_on = val[0];
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // result checker and receiver stalls
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (answers_due.size() == 0) begin
                $display("unexpected result beat");
                errors++;
            end else begin
                answer_t a;
                a = answers_due.pop_front();
                if (m_hit !== a.hit) report_mismatch("hit", m_hit, a.hit);
                if (m_found_mac !== a.mac) report_mismatch("found_mac", m_found_mac, a.mac);
                if (m_found_port !== a.port) report_mismatch("found_port", m_found_port, a.port);
                if (m_request_needed !== a.req)
                    report_mismatch("request_needed", m_request_needed, a.req);
                if (m_status !== a.status) report_mismatch("status", m_status, a.status);
                n_hits += a.hit;
                n_full += (a.status == arpnc_pkg::ST_FULL);
                n_conflict += (a.status == arpnc_pkg::ST_CONFLICT);
                n_checked++;
            end
        end
    end

    initial begin : sink
        int gap;
        forever begin
            @(posedge aclk);
            if (hold_off || (!no_sink_gaps && gap > 0)) begin
                m_ready <= 1'b0;
                if (gap > 0) gap--;
            end else begin
                m_ready <= 1'b1;
                if (m_valid && m_ready) gap = $urandom_range(0, 5);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic test_directed();
        logic [31:0] ip;
        ip = 32'h0A00_0001;
        send_item(arpnc_pkg::FUNC_LOOKUP, ip, '0, '0, '0, 1'b1, '0, '0, '0, '0, '0);
        send_item(arpnc_pkg::FUNC_LOOKUP, ip, '0, '0, '0, 1'b0, '0, '0, '0, '0, '0);
        send_item(arpnc_pkg::FUNC_ADD, ip, '0, 48'hFFFF_FFFF_FFFF, 8'hFF, 1'b0, '0, '0, '0,
                  '0, '0);
        send_item(arpnc_pkg::FUNC_LOOKUP, ip, '0, '0, '0, 1'b0, '0, '0, '0, '0, '0);
        send_item(arpnc_pkg::FUNC_ADD, ip, '0, 48'h0, 8'h0, 1'b0, '0, '0, '0, '0, '0);
        send_item(arpnc_pkg::FUNC_ADD, 32'h0, '0, 48'h1234, 8'h1, 1'b0, '0, '0, '0, '0, '0);
        send_item(arpnc_pkg::FUNC_LOOKUP, 32'h0, '0, '0, '0, 1'b1, '0, '0, '0, '0, '0);
        // five keys of one bucket, last finds it full
        for (int k = 0; k < 5; k++)
            send_item(arpnc_pkg::FUNC_ADD, {16'(k + 1), 16'(k + 1) ^ 16'h0055}, '0, 48'(k),
                      8'(k), 1'b0, '0, '0, '0, '0, '0);
        send_item(arpnc_pkg::FUNC_ADD, 32'hFFFF_FFFF, '0, 48'h5, 8'h5, 1'b0, '0, '0, '0, '0,
                  '0);
        send_item(arpnc_pkg::FUNC_NONE, ip, ip, 48'h1, 8'h1, 1'b1, arpnc_pkg::MIN_FRAME,
                  arpnc_pkg::HW_ETHERNET, arpnc_pkg::PROTO_IPV4, arpnc_pkg::HW_LEN_ETH,
                  arpnc_pkg::PROTO_LEN4);
        // malformed learns, one check each
        send_item(arpnc_pkg::FUNC_LEARN, 32'h0B, '0, 48'h2, 8'h2, 1'b0,
                  arpnc_pkg::MIN_FRAME - 16'd1, arpnc_pkg::HW_ETHERNET,
                  arpnc_pkg::PROTO_IPV4, arpnc_pkg::HW_LEN_ETH, arpnc_pkg::PROTO_LEN4);
        send_item(arpnc_pkg::FUNC_LEARN, 32'h0B, '0, 48'h2, 8'h2, 1'b0, 16'hFFFF, 16'd6,
                  arpnc_pkg::PROTO_IPV4, arpnc_pkg::HW_LEN_ETH, arpnc_pkg::PROTO_LEN4);
        send_item(arpnc_pkg::FUNC_LEARN, 32'h0B, '0, 48'h2, 8'h2, 1'b0, arpnc_pkg::MIN_FRAME,
                  arpnc_pkg::HW_ETHERNET, 16'h86DD, arpnc_pkg::HW_LEN_ETH,
                  arpnc_pkg::PROTO_LEN4);
        send_item(arpnc_pkg::FUNC_LEARN, 32'h0B, '0, 48'h2, 8'h2, 1'b0, arpnc_pkg::MIN_FRAME,
                  arpnc_pkg::HW_ETHERNET, arpnc_pkg::PROTO_IPV4, 8'hFF,
                  arpnc_pkg::PROTO_LEN4);
        send_item(arpnc_pkg::FUNC_LEARN, 32'h0B, '0, 48'h2, 8'h2, 1'b0, arpnc_pkg::MIN_FRAME,
                  arpnc_pkg::HW_ETHERNET, arpnc_pkg::PROTO_IPV4, arpnc_pkg::HW_LEN_ETH,
                  8'd0);
        send_learn(32'h0, 32'h1, 48'h3, 8'h3);
        send_learn(32'h0B, 32'h1, 48'h4, 8'h4);
        send_learn(32'h0B, 32'h1, 48'h5, 8'h5);
        drain();
        write_reg(arpnc_pkg::CFG_LOCAL_IP, 32'h0B);
        write_reg(arpnc_pkg::CFG_LOCAL_IP_VALID, 32'h1);
        send_learn(32'h0B, 32'h2, 48'h6, 8'h6);
        send_learn(32'h0B, 32'h0B, 48'h6, 8'h6);
        send_item(arpnc_pkg::FUNC_LOOKUP, 32'h0B, '0, '0, '0, 1'b0, '0, '0, '0, '0, '0);
        drain();
    endtask

    task automatic send_random(int count);
        arpnc_pkg::func_t f;
        logic [31:0] ip;
        logic [31:0] tip;
        logic [15:0] flen;
        bit good;
        for (int n = 0; n < count; n++) begin
            // keys drawn from a small pool so hits, updates and full buckets occur
            if (recent_ips.size() == 0 || $urandom_range(0, 3) == 0) begin
                ip = ($urandom_range(0, 1)) ? $urandom()
                     : {16'($urandom_range(0, 15)), 16'($urandom_range(0, 15))};
                recent_ips.push_back(ip);
                if (recent_ips.size() > 64) void'(recent_ips.pop_front());
            end else begin
                ip = recent_ips[$urandom_range(0, recent_ips.size() - 1)];
            end
            if ($urandom_range(0, 15) == 0) ip = my_ip;
            f = arpnc_pkg::func_t'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
            tip = $urandom_range(0, 1) ? ip : $urandom();
            good = $urandom_range(0, 4) != 0;
            flen = good ? 16'($urandom_range(42, 65535)) : 16'($urandom());
            if (good)
                send_item(f, ip, tip, {$urandom(), 16'($urandom())}, 8'($urandom()),
                          1'($urandom()), flen, arpnc_pkg::HW_ETHERNET,
                          arpnc_pkg::PROTO_IPV4, arpnc_pkg::HW_LEN_ETH,
                          arpnc_pkg::PROTO_LEN4);
            else
                send_item(f, ip, tip, {$urandom(), 16'($urandom())}, 8'($urandom()),
                          1'($urandom()), flen, 16'($urandom()), 16'($urandom()),
                          8'($urandom()), 8'($urandom()));
        end
    endtask

    task automatic test_random();
        send_random(200);
        drain();
        write_reg(arpnc_pkg::CFG_LOCAL_IP, 32'hFFFF_FFFF);
        write_reg(arpnc_pkg::CFG_LOCAL_IP_VALID, 32'h1);
        no_sink_gaps = 1;
        no_src_gaps = 1;
        send_random(100);
        no_sink_gaps = 0;
        no_src_gaps = 0;
        drain();
        write_reg(arpnc_pkg::CFG_LOCAL_IP, 32'h0);
        write_reg(arpnc_pkg::CFG_LOCAL_IP_VALID, 32'h0);
        send_random(150);
        drain();
        write_reg(arpnc_pkg::CFG_LOCAL_IP, $urandom());
        write_reg(arpnc_pkg::CFG_LOCAL_IP_VALID, 32'h1);
        send_random(150);
        drain();
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1;
                wait_cycles(300);
                hold_off = 0;
            end
            begin
                no_src_gaps = 1;
                send_random(20);
                s_valid <= 1'b0;
                no_src_gaps = 0;
            end
        join
        drain();
    endtask

    initial begin
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_hits = 0;
        n_full = 0;
        n_conflict = 0;
        cycles = 0;
        hold_off = 0;
        no_sink_gaps = 0;
        no_src_gaps = 0;
        conflicts = '0;
        misses = '0;
        my_ip = '0;
        my_ip_on = 1'b0;
        for (int i = 0; i < NB * NW; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_ip[i] = '0;
            tbl_mac[i] = '0;
            tbl_port[i] = '0;
        end
        wait_cycles(3);
        aresetn <= 1'b1;
        test_directed();
        test_random();
        test_backpressure();
        $display("%0d items sent, %0d results checked: %0d hits, %0d table full, %0d conflicts",
                 n_sent, n_checked, n_hits, n_full, n_conflict);
        $display("covered lookup, add, learn, header checks, local address and stalls");
        if (errors == 0 && answers_due.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
